>>> hw/rtl/ocsu_pkg.sv
// Package for the occupancy score cell update unit.
// Holds grid constants, field types, state entry layouts and register codes.
// No dependencies; every other file of the block but ocsu_ram imports it.
`timescale 1ns / 1ps

package ocsu_pkg;

	// Grid geometry and record width
	localparam int GRID_WIDTH  = 256;
	localparam int GRID_HEIGHT = 256;
	localparam int COUNT_BITS  = 16;

	localparam int CELLS     = GRID_WIDTH * GRID_HEIGHT;
	localparam int CELL_BITS = (CELLS > 1) ? $clog2(CELLS) : 1;

	// Configuration register indexes
	localparam int          CFG_INDEX_BITS     = 3;
	localparam int          CFG_DATA_BITS      = 16;
	localparam logic [2:0]  REG_HIT_WEIGHT     = 3'd0;
	localparam logic [2:0]  REG_MISS_WEIGHT    = 3'd1;
	localparam logic [2:0]  REG_MIN_SCORE      = 3'd2;
	localparam logic [2:0]  REG_MAX_SCORE      = 3'd3;
	localparam logic [2:0]  REG_FREE_SCORE     = 3'd4;
	localparam logic [2:0]  REG_OCCUPIED_SCORE = 3'd5;

	// Stream widths
	localparam int S_DATA_BITS = 56;
	localparam int M_DATA_BITS = 88;

	typedef enum logic [1:0] {
		CLASS_UNKNOWN  = 2'd0,
		CLASS_FREE     = 2'd1,
		CLASS_OCCUPIED = 2'd2
	} cell_class_t;

	// Register file contents
	typedef struct packed {
		logic        [14:0] hit_step;
		logic        [14:0] miss_step;
		logic signed [15:0] score_floor;
		logic signed [15:0] score_ceil;
		logic signed [15:0] free_level;
		logic signed [15:0] occ_level;
	} cfg_t;

	// Per-cell entry that the clearing pass resets
	typedef struct packed {
		logic signed [15:0] score;
		cell_class_t        cls;
		logic               active;
	} cell_state_t;

	// Per-cell occupancy record, only meaningful while active
	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic signed [15:0]    low_z;
		logic signed [15:0]    high_z;
		logic                  z_seen;
	} cell_rec_t;

	localparam int STATE_BITS = $bits(cell_state_t);
	localparam int REC_BITS   = $bits(cell_rec_t);

	// One result item
	typedef struct packed {
		logic               in_grid;
		cell_class_t        class_after;
		logic signed [15:0] score_old;
		logic signed [15:0] score_new;
		logic               newly_occupied;
		logic               has_record;
		logic        [15:0] hit_count;
		logic signed [15:0] min_z;
		logic signed [15:0] max_z;
		logic               z_known;
	} result_t;

	// Record count reported on the result, saturated to 16 bits
	function automatic logic [15:0] sat_count(input logic [COUNT_BITS-1:0] c);
		logic [COUNT_BITS+15:0] wide;
		wide = {16'b0, c};
		if (wide > (COUNT_BITS + 16)'(17'h0FFFF))
			return 16'hFFFF;
		return wide[15:0];
	endfunction

endpackage

>>> hw/rtl/ocsu_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old contents. No dependencies.
`timescale 1ns / 1ps

module ocsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/ocsu_cfg_regs.sv
// Configuration register file with consistency check of the thresholds.
// Depends on ocsu_pkg.
`timescale 1ns / 1ps

module ocsu_cfg_regs
	import ocsu_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output cfg_t                      cfg,
	output logic                      consistent
);

	cfg_t cfg_q;

	// Register writes; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hit_step    <= 15'd4;
			cfg_q.miss_step   <= 15'd1;
			cfg_q.score_floor <= -16'sd20;
			cfg_q.score_ceil  <= 16'sd20;
			cfg_q.free_level  <= -16'sd5;
			cfg_q.occ_level   <= 16'sd5;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HIT_WEIGHT:     cfg_q.hit_step    <= cfg_data[14:0];
				REG_MISS_WEIGHT:    cfg_q.miss_step   <= cfg_data[14:0];
				REG_MIN_SCORE:      cfg_q.score_floor <= cfg_data;
				REG_MAX_SCORE:      cfg_q.score_ceil  <= cfg_data;
				REG_FREE_SCORE:     cfg_q.free_level  <= cfg_data;
				REG_OCCUPIED_SCORE: cfg_q.occ_level   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// Items are dropped unless weights and limits make sense together
	always_comb begin
		consistent = (cfg_q.hit_step != 15'd0) && (cfg_q.miss_step != 15'd0) &&
			($signed(cfg_q.score_floor) < $signed(cfg_q.score_ceil)) &&
			($signed(cfg_q.free_level) >= $signed(cfg_q.score_floor)) &&
			($signed(cfg_q.occ_level) <= $signed(cfg_q.score_ceil)) &&
			($signed(cfg_q.free_level) < $signed(cfg_q.occ_level));
	end

endmodule

>>> hw/rtl/ocsu_cell_update.sv
// Modify step of the read-modify-write: score update, classification,
// record start or extension and the result fields. Depends on ocsu_pkg.
`timescale 1ns / 1ps

module ocsu_cell_update
	import ocsu_pkg::*;
(
	input  cfg_t               cfg,
	input  logic               kind,
	input  logic signed [15:0] endpoint_z,
	input  logic               endpoint_z_valid,
	input  cell_state_t        cur_state,
	input  cell_rec_t          cur_rec,
	output cell_state_t        nxt_state,
	output cell_rec_t          nxt_rec,
	output result_t            res
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic signed [17:0] before_w;
	logic signed [17:0] sum_w;
	logic signed [17:0] min_w;
	logic signed [17:0] max_w;
	logic signed [17:0] clamp_w;
	logic signed [15:0] after;
	cell_class_t        cls;
	logic               occ_before;
	logic               occ_after;
	logic               start_rec;
	logic               extend_rec;
	logic               active_after;

	// Score add or subtract and clamp
	always_comb begin
		before_w = {{2{cur_state.score[15]}}, cur_state.score};
		min_w    = {{2{cfg.score_floor[15]}}, cfg.score_floor};
		max_w    = {{2{cfg.score_ceil[15]}}, cfg.score_ceil};
		if (kind)
			sum_w = before_w + $signed({3'b000, cfg.hit_step});
		else
			sum_w = before_w - $signed({3'b000, cfg.miss_step});
		clamp_w = sum_w;
		if (sum_w < min_w)
			clamp_w = min_w;
		if (sum_w > max_w)
			clamp_w = max_w;
		after = clamp_w[15:0];
	end

	// Classification after the update
	always_comb begin
		priority if ($signed(after) >= $signed(cfg.occ_level))
			cls = CLASS_OCCUPIED;
		else if ($signed(after) <= $signed(cfg.free_level))
			cls = CLASS_FREE;
		else
			cls = CLASS_UNKNOWN;
	end

	// Record: cleared on leaving occupied, started or extended by a hit
	always_comb begin
		occ_before   = (cur_state.cls == CLASS_OCCUPIED);
		occ_after    = (cls == CLASS_OCCUPIED);
		start_rec    = kind && occ_after && (!occ_before || !cur_state.active);
		extend_rec   = kind && occ_after && occ_before && cur_state.active;
		active_after = occ_after && (cur_state.active || start_rec);

		nxt_rec = cur_rec;
		if (start_rec) begin
			nxt_rec.count  = COUNT_BITS'(1);
			nxt_rec.z_seen = endpoint_z_valid;
			nxt_rec.low_z  = endpoint_z_valid ? endpoint_z : 16'sd0;
			nxt_rec.high_z = endpoint_z_valid ? endpoint_z : 16'sd0;
		end else if (extend_rec) begin
			if (cur_rec.count != COUNT_MAX)
				nxt_rec.count = cur_rec.count + COUNT_BITS'(1);
			if (endpoint_z_valid) begin
				if (!cur_rec.z_seen) begin
					nxt_rec.low_z  = endpoint_z;
					nxt_rec.high_z = endpoint_z;
					nxt_rec.z_seen = 1'b1;
				end else begin
					if ($signed(endpoint_z) < $signed(cur_rec.low_z))
						nxt_rec.low_z = endpoint_z;
					if ($signed(endpoint_z) > $signed(cur_rec.high_z))
						nxt_rec.high_z = endpoint_z;
				end
			end
		end

		nxt_state.score  = after;
		nxt_state.cls    = cls;
		nxt_state.active = active_after;
	end

	// Result fields; record fields read as zero without a record
	always_comb begin
		res                = '0;
		res.in_grid        = 1'b1;
		res.class_after    = cls;
		res.score_old      = cur_state.score;
		res.score_new      = after;
		res.newly_occupied = kind && occ_after && !occ_before;
		if (active_after) begin
			res.has_record = 1'b1;
			res.hit_count  = sat_count(nxt_rec.count);
			if (nxt_rec.z_seen) begin
				res.min_z   = nxt_rec.low_z;
				res.max_z   = nxt_rec.high_z;
				res.z_known = 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/occupancy_score_cell_update_unit.sv
// Top level of the occupancy score cell update unit.
// Depends on ocsu_pkg, ocsu_ram, ocsu_cfg_regs and ocsu_cell_update.
`timescale 1ns / 1ps

// Takes one cell update per clock while the output side is not stalled and
// returns one result per item through stage 1 and the output register. The rate
// is set by the read-modify-write over the per-cell state memories (registered
// read): the read is issued at the input transfer, the update is written back as
// the item leaves stage 1, and a write that coincides with the read of the next
// item to the same cell is forwarded. After reset a clearing pass writes the
// score/class/record-active memory, one cell per cycle, over all CELLS cells
// (65536 for a 256 x 256 grid) with s_tready low; configuration writes are
// taken throughout. Items outside the grid or arriving while the thresholds are
// inconsistent give an all-zero result and leave the cell alone.
module occupancy_score_cell_update_unit
	import ocsu_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration write port
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	// Input stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// cell_x[15:0], cell_y[31:16], endpoint_z[47:32], endpoint_z_valid[48], zero[55:49]
	input  logic [S_DATA_BITS-1:0]    s_tdata,
	// kind[0]
	input  logic [0:0]                s_tuser,
	// Output stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// in_grid[0], class_after[2:1], score_old[18:3], score_new[34:19],
	// newly_occupied[35], has_record[36], hit_count[52:37], min_z[68:53],
	// max_z[84:69], z_known[85], zero[87:86]
	output logic [M_DATA_BITS-1:0]    m_tdata
);

	cfg_t cfg;
	logic consistent;

	ocsu_cfg_regs u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg        (cfg),
		.consistent (consistent)
	);

	// Input decode and cell address
	logic               s_accept;
	logic signed [15:0] in_x;
	logic signed [15:0] in_y;
	logic               in_grid_chk;
	logic [31:0]        idx_full;
	logic [CELL_BITS-1:0] idx_in;

	assign s_accept = s_tvalid && s_tready;
	assign in_x     = s_tdata[15:0];
	assign in_y     = s_tdata[31:16];

	always_comb begin
		in_grid_chk = !in_x[15] && (in_x < 16'(GRID_WIDTH)) &&
			!in_y[15] && (in_y < 16'(GRID_HEIGHT));
		idx_full = {16'b0, in_y} * 32'(GRID_WIDTH) + {16'b0, in_x};
		idx_in   = idx_full[CELL_BITS-1:0];
	end

	// Stage 1 registers: item waiting for its memory data
	logic                 valid_s1;
	logic                 upd_s1;
	logic [CELL_BITS-1:0] idx_s1;
	logic                 kind_s1;
	logic signed [15:0]   z_s1;
	logic                 zv_s1;
	logic                 fwd_s1;
	cell_state_t          fwd_state_s1;
	cell_rec_t            fwd_rec_s1;

	// Clearing pass
	logic                 clearing_q;
	logic [CELL_BITS-1:0] clr_addr_q;

	// Output register
	logic                   m_valid_q;
	logic [M_DATA_BITS-1:0] m_data_q;

	logic out_free;
	logic s1_adv;
	logic s1_write;

	assign out_free = !m_valid_q || m_tready;
	assign s1_adv   = valid_s1 && out_free;
	assign s1_write = s1_adv && upd_s1;
	assign s_tready = !clearing_q && (!valid_s1 || out_free);

	// State memories
	logic [STATE_BITS-1:0] state_rdata;
	logic [REC_BITS-1:0]   rec_rdata;
	logic                  state_we;
	logic [CELL_BITS-1:0]  state_waddr;
	logic [STATE_BITS-1:0] state_wdata;
	cell_state_t           cur_state;
	cell_rec_t             cur_rec;
	cell_state_t           nxt_state;
	cell_rec_t             nxt_rec;
	result_t               res_calc;
	result_t               res;

	always_comb begin
		state_we    = clearing_q || s1_write;
		state_waddr = clearing_q ? clr_addr_q : idx_s1;
		state_wdata = clearing_q ? STATE_BITS'(0) : STATE_BITS'(nxt_state);
	end

	ocsu_ram #(
		.WIDTH (STATE_BITS),
		.DEPTH (CELLS)
	) u_state_ram (
		.clk   (clk),
		.we    (state_we),
		.waddr (state_waddr),
		.wdata (state_wdata),
		.re    (s_accept),
		.raddr (idx_in),
		.rdata (state_rdata)
	);

	ocsu_ram #(
		.WIDTH (REC_BITS),
		.DEPTH (CELLS)
	) u_rec_ram (
		.clk   (clk),
		.we    (s1_write),
		.waddr (idx_s1),
		.wdata (REC_BITS'(nxt_rec)),
		.re    (s_accept),
		.raddr (idx_in),
		.rdata (rec_rdata)
	);

	// Forwarded write from the item ahead takes the place of the stale read
	always_comb begin
		cur_state = fwd_s1 ? fwd_state_s1 : cell_state_t'(state_rdata);
		cur_rec   = fwd_s1 ? fwd_rec_s1 : cell_rec_t'(rec_rdata);
	end

	ocsu_cell_update u_update (
		.cfg              (cfg),
		.kind             (kind_s1),
		.endpoint_z       (z_s1),
		.endpoint_z_valid (zv_s1),
		.cur_state        (cur_state),
		.cur_rec          (cur_rec),
		.nxt_state        (nxt_state),
		.nxt_rec          (nxt_rec),
		.res              (res_calc)
	);

	assign res = upd_s1 ? res_calc : '0;

	// Clearing pass sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + CELL_BITS'(1);
			if (clr_addr_q == CELL_BITS'(CELLS - 1))
				clearing_q <= 1'b0;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_accept)
			valid_s1 <= 1'b1;
		else if (s1_adv)
			valid_s1 <= 1'b0;
	end

	// Stage 1 payload and forwarding capture
	always_ff @(posedge clk) begin
		if (s_accept) begin
			upd_s1       <= consistent && in_grid_chk;
			idx_s1       <= idx_in;
			kind_s1      <= s_tuser[0];
			z_s1         <= s_tdata[47:32];
			zv_s1        <= s_tdata[48];
			fwd_s1       <= s1_write && (idx_s1 == idx_in);
			fwd_state_s1 <= nxt_state;
			fwd_rec_s1   <= nxt_rec;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (s1_adv)
			m_valid_q <= 1'b1;
		else if (m_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			m_data_q <= {2'b00, res.z_known, res.max_z, res.min_z, res.hit_count,
				res.has_record, res.newly_occupied, res.score_new, res.score_old,
				res.class_after, res.in_grid};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

`ifndef ASSERT_OFF
	// No transfer is taken while the memory is being cleared
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !s_tready)
		else $error("input transfer during clearing pass");

	// A write-back to the cell just read must be forwarded to the next item
	a_forward_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s1_write && (idx_s1 == idx_in)) |=> fwd_s1)
		else $error("missed forwarding of same-cell write");

	// A newly occupied cell always carries a record
	a_newly_has_record: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[35]) |-> (m_tdata[36] && m_tdata[0]))
		else $error("newly occupied result without record");

	// Occupied class only at or above the occupied threshold
	a_occupied_score: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[2:1] == CLASS_OCCUPIED)) |->
		($signed(m_tdata[34:19]) >= $signed(cfg.occ_level)))
		else $error("occupied class below threshold");
`endif

endmodule

>>> dv/tb.sv
// Self-checking bench for the occupancy score cell update unit.
// Holds its own cell score and record model and checks every result transfer;
// depends only on ocsu_pkg and occupancy_score_cell_update_unit.
`timescale 1ns / 1ps

module tb;
	import ocsu_pkg::*;

	localparam logic KIND_MISS = 1'b0;
	localparam logic KIND_HIT  = 1'b1;

	localparam int IDLE_NONE = 0;
	localparam int IDLE_TX   = 1;
	localparam int IDLE_RX   = 2;
	localparam int IDLE_BOTH = 3;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SOAK_HITS   = 40;
	localparam longint unsigned COUNT_MAX = (COUNT_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
		((64'd1 << COUNT_BITS) - 64'd1);

	// Result field layout on m_tdata, lowest first
	localparam int FIELD_LSB [10] = '{0, 1, 3, 19, 35, 36, 37, 53, 69, 85};
	localparam int FIELD_W   [10] = '{1, 2, 16, 16, 1, 1, 16, 16, 16, 1};

	typedef struct {
		logic               kind;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               zv;
	} cell_item_t;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [S_DATA_BITS-1:0]    s_tdata   = '0;
	logic [0:0]                s_tuser   = '0;
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [M_DATA_BITS-1:0]    m_tdata;

	// Register shadow used by the prediction
	logic        [14:0] hit_w;
	logic        [14:0] miss_w;
	logic signed [15:0] lim_lo;
	logic signed [15:0] lim_hi;
	logic signed [15:0] free_thr;
	logic signed [15:0] occ_thr;

	// Per-cell model state
	logic signed [15:0] cell_score [CELLS];
	cell_class_t        cell_cls   [CELLS];
	logic               rec_on     [CELLS];
	longint unsigned    rec_cnt    [CELLS];
	logic signed [15:0] rec_lo     [CELLS];
	logic signed [15:0] rec_hi     [CELLS];
	logic               rec_z_seen [CELLS];

	cell_item_t  cell_updates_todo [$];
	cell_item_t  in_flight;
	result_t     due_results [$];

	int unsigned tx_idle_pct  = 0;
	int unsigned rx_stall_pct = 0;
	int          n_items   = 0;
	int          n_checked = 0;
	int          n_errors  = 0;
	int          n_cfg     = 0;
	int          cycles    = 0;

	occupancy_score_cell_update_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expected result of one cell update; advances the model state
	function automatic result_t score_update(cell_item_t it);
		result_t     r;
		int          idx;
		int          old_score;
		int          after;
		logic        occ_before;
		cell_class_t cls;
		r = '0;
		if (hit_w == 0 || miss_w == 0 || lim_lo >= lim_hi || free_thr < lim_lo ||
			occ_thr > lim_hi || free_thr >= occ_thr)
			return r;
		if (it.x < 0 || it.x >= GRID_WIDTH || it.y < 0 || it.y >= GRID_HEIGHT)
			return r;
		idx = int'(it.y) * GRID_WIDTH + int'(it.x);
		old_score = int'(cell_score[idx]);
		occ_before = (cell_cls[idx] == CLASS_OCCUPIED);
		if (it.kind == KIND_HIT)
			after = old_score + int'(hit_w);
		else
			after = old_score - int'(miss_w);
		if (after < lim_lo)
			after = int'(lim_lo);
		if (after > lim_hi)
			after = int'(lim_hi);
		cell_score[idx] = 16'(after);
		// leaving occupied drops the record
		if (after >= occ_thr) begin
			cls = CLASS_OCCUPIED;
		end else begin
			rec_on[idx] = 1'b0;
			cls = (after <= free_thr) ? CLASS_FREE : CLASS_UNKNOWN;
		end
		cell_cls[idx] = cls;
		if (it.kind == KIND_HIT && cls == CLASS_OCCUPIED) begin
			if (!occ_before || !rec_on[idx]) begin
				rec_on[idx]     = 1'b1;
				rec_cnt[idx]    = 64'd1;
				rec_z_seen[idx] = it.zv;
				rec_lo[idx]     = it.zv ? it.z : 16'sd0;
				rec_hi[idx]     = it.zv ? it.z : 16'sd0;
			end else begin
				if (rec_cnt[idx] < COUNT_MAX)
					rec_cnt[idx]++;
				if (it.zv) begin
					if (!rec_z_seen[idx]) begin
						rec_lo[idx]     = it.z;
						rec_hi[idx]     = it.z;
						rec_z_seen[idx] = 1'b1;
					end else begin
						if (it.z < rec_lo[idx])
							rec_lo[idx] = it.z;
						if (it.z > rec_hi[idx])
							rec_hi[idx] = it.z;
					end
				end
			end
			r.newly_occupied = !occ_before;
		end
		r.in_grid     = 1'b1;
		r.class_after = cls;
		r.score_old   = 16'(old_score);
		r.score_new   = 16'(after);
		if (rec_on[idx]) begin
			r.has_record = 1'b1;
			r.hit_count  = (rec_cnt[idx] > 64'hFFFF) ? 16'hFFFF : 16'(rec_cnt[idx]);
			if (rec_z_seen[idx]) begin
				r.min_z   = rec_lo[idx];
				r.max_z   = rec_hi[idx];
				r.z_known = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic string field_name(int f);
		case (f)
			0: return "in_grid";
			1: return "class_after";
			2: return "score_old";
			3: return "score_new";
			4: return "newly_occupied";
			5: return "has_record";
			6: return "hit_count";
			7: return "min_z";
			8: return "max_z";
			default: return "z_known";
		endcase
	endfunction

	// Input side: one pending cell update per transfer, random gaps
	always @(posedge clk) begin : drive_cells
		cell_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (cell_updates_todo.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				nxt = cell_updates_todo.pop_front();
				s_tdata   <= {7'b0, nxt.zv, nxt.z, nxt.y, nxt.x};
				s_tuser   <= nxt.kind;
				in_flight <= nxt;
				s_tvalid  <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output side: random stalls, compare against oldest due result, then
	// predict for the input transfer of this edge
	always @(posedge clk) begin : check_results
		result_t     want;
		logic [85:0] want_bits;
		logic [85:0] got_bits;
		logic [85:0] mask;
		string       diffs;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected result transfer: %0h", m_tdata);
				end else begin
					want = due_results.pop_front();
					want_bits = {want.z_known, want.max_z, want.min_z, want.hit_count,
						want.has_record, want.newly_occupied, want.score_new,
						want.score_old, want.class_after, want.in_grid};
					got_bits = m_tdata[85:0];
					diffs = "";
					for (int f = 0; f < 10; f++) begin
						mask = ((86'd1 << FIELD_W[f]) - 86'd1) << FIELD_LSB[f];
						if (((want_bits ^ got_bits) & mask) !== 86'd0)
							diffs = {diffs, $sformatf(" %s exp %0h got %0h", field_name(f),
								(want_bits & mask) >> FIELD_LSB[f],
								(got_bits & mask) >> FIELD_LSB[f])};
					end
					n_checked++;
					if (diffs != "") begin
						n_errors++;
						if (n_errors <= 10)
							$display("result %0d mismatch:%s", n_checked, diffs);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				due_results.insert(due_results.size(), score_update(in_flight));
				n_items++;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				due_results.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic reg_write(input logic [CFG_INDEX_BITS-1:0] idx, input logic [15:0] d);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		case (idx)
			REG_HIT_WEIGHT:     hit_w    = d[14:0];
			REG_MISS_WEIGHT:    miss_w   = d[14:0];
			REG_MIN_SCORE:      lim_lo   = d;
			REG_MAX_SCORE:      lim_hi   = d;
			REG_FREE_SCORE:     free_thr = d;
			REG_OCCUPIED_SCORE: occ_thr  = d;
			default: ;
		endcase
	endtask

	task automatic write_cfg(input int hw, input int mw, input int mn, input int mx,
		input int fr, input int oc);
		reg_write(REG_HIT_WEIGHT, 16'(hw));
		reg_write(REG_MISS_WEIGHT, 16'(mw));
		reg_write(REG_MIN_SCORE, 16'(mn));
		reg_write(REG_MAX_SCORE, 16'(mx));
		reg_write(REG_FREE_SCORE, 16'(fr));
		reg_write(REG_OCCUPIED_SCORE, 16'(oc));
		@(posedge clk);
		cfg_we <= 1'b0;
		n_cfg++;
	endtask

	// Random consistent thresholds in a narrow band so cells change class often
	task automatic rand_cfg();
		int lo;
		int hi;
		int fr;
		int oc;
		lo = -int'($urandom_range(2, 60));
		hi = $urandom_range(2, 60);
		fr = lo + int'($urandom_range(0, hi - lo - 1));
		oc = fr + 1 + int'($urandom_range(0, hi - fr - 1));
		write_cfg($urandom_range(1, 8) | ($urandom_range(0, 1) << 15),
			$urandom_range(1, 8) | ($urandom_range(0, 1) << 15), lo, hi, fr, oc);
	endtask

	task automatic set_idle(input int mode);
		case (mode)
			IDLE_TX:   begin tx_idle_pct = 55; rx_stall_pct = 0;  end
			IDLE_RX:   begin tx_idle_pct = 0;  rx_stall_pct = 55; end
			IDLE_BOTH: begin tx_idle_pct = 14; rx_stall_pct = 14; end
			default:   begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
		endcase
	endtask

	// Block idle: nothing queued, nothing offered, nothing due
	task automatic wait_idle();
		@(negedge clk);
		while (cell_updates_todo.size() != 0 || s_tvalid || due_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic add_item(input logic kind, input int x, input int y, input int z,
		input logic zv);
		cell_item_t it;
		it.kind = kind;
		it.x    = 16'(x);
		it.y    = 16'(y);
		it.z    = 16'(z);
		it.zv   = zv;
		cell_updates_todo.insert(cell_updates_todo.size(), it);
	endtask

	// Mostly traffic on a few hot cells so scores and records build up,
	// with repeats on one cell, scattered grid cells and off-grid noise
	task automatic random_burst(input int n);
		int unsigned        hit_bias;
		int unsigned        r;
		logic signed [15:0] px;
		logic signed [15:0] py;
		px = 0;
		py = 0;
		hit_bias = 50;
		@(negedge clk);
		for (int i = 0; i < n; i++) begin
			if (i % 25 == 0)
				hit_bias = $urandom_range(15, 90);
			r = $urandom_range(0, 99);
			if (r < 25 && i != 0) begin
				// same cell again, back to back
			end else if (r < 75) begin
				case ($urandom_range(0, 7))
					0: begin px = 16'sd0;   py = 16'sd0;   end
					1: begin px = 16'sd255; py = 16'sd255; end
					2: begin px = 16'sd0;   py = 16'sd255; end
					3: begin px = 16'sd255; py = 16'sd0;   end
					4: begin px = 16'sd3;   py = 16'sd7;   end
					5: begin px = 16'sd128; py = 16'sd64;  end
					6: begin px = 16'sd200; py = 16'sd17;  end
					default: begin px = 16'sd9; py = 16'sd9; end
				endcase
			end else if (r < 88) begin
				px = 16'($urandom_range(0, GRID_WIDTH - 1));
				py = 16'($urandom_range(0, GRID_HEIGHT - 1));
			end else if (r < 96) begin
				px = 16'($urandom);
				py = 16'($urandom);
				if (px >= 0 && px < GRID_WIDTH && py >= 0 && py < GRID_HEIGHT)
					px = -px - 16'sd1;
			end else begin
				// just past an edge
				px = (r % 2 != 0) ? 16'sd256 : -16'sd1;
				py = 16'($urandom_range(0, GRID_HEIGHT - 1));
				if (r == 98) begin
					px = py;
					py = 16'sd256;
				end
			end
			add_item(($urandom_range(0, 99) < hit_bias) ? KIND_HIT : KIND_MISS, px, py,
				$urandom, $urandom_range(0, 99) < 75);
		end
	endtask

	initial begin : main
		for (int i = 0; i < CELLS; i++) begin
			cell_score[i] = '0;
			cell_cls[i]   = CLASS_UNKNOWN;
			rec_on[i]     = 1'b0;
			rec_cnt[i]    = '0;
			rec_lo[i]     = '0;
			rec_hi[i]     = '0;
			rec_z_seen[i] = 1'b0;
		end
		hit_w    = 15'd4;
		miss_w   = 15'd1;
		lim_lo   = -16'sd20;
		lim_hi   = 16'sd20;
		free_thr = -16'sd5;
		occ_thr  = 16'sd5;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values written back explicitly, during the clearing pass
		write_cfg(4, 1, -20, 20, -5, 5);

		// Directed: record start, extension, clamp, free, off-grid
		set_idle(IDLE_NONE);
		@(negedge clk);
		add_item(KIND_HIT, 0, 0, -32768, 1'b1);
		add_item(KIND_HIT, 0, 0, 32767, 1'b1);
		add_item(KIND_HIT, 0, 0, 0, 1'b0);
		add_item(KIND_HIT, 0, 0, -32768, 1'b1);
		add_item(KIND_HIT, 0, 0, 5, 1'b1);
		add_item(KIND_HIT, 0, 0, 7, 1'b1);
		add_item(KIND_MISS, 0, 0, 0, 1'b0);
		add_item(KIND_HIT, 255, 255, 0, 1'b0);
		add_item(KIND_HIT, 255, 255, 32767, 1'b0);
		add_item(KIND_HIT, 255, 255, -100, 1'b1);
		add_item(KIND_MISS, 255, 255, 0, 1'b0);
		add_item(KIND_MISS, 255, 255, 0, 1'b0);
		add_item(KIND_MISS, 255, 255, 0, 1'b0);
		add_item(KIND_MISS, 255, 255, 0, 1'b0);
		add_item(KIND_HIT, 255, 255, 1, 1'b1);
		for (int i = 0; i < 5; i++)
			add_item(KIND_MISS, 255, 0, 0, 1'b0);
		add_item(KIND_HIT, -1, 0, 10, 1'b1);
		add_item(KIND_MISS, 256, 0, 0, 1'b0);
		add_item(KIND_MISS, 0, 256, 0, 1'b1);
		add_item(KIND_HIT, -32768, 32767, 32767, 1'b1);
		add_item(KIND_MISS, 32767, -32768, -32768, 1'b0);
		wait_idle();

		// Long run of hits on one cell: record count and height range grow
		for (int i = 0; i < SOAK_HITS; i++)
			add_item(KIND_HIT, 17, 200, $urandom, $urandom_range(0, 99) < 80);
		wait_idle();

		// Reset settings; halfway the sender holds off until all results are back
		set_idle(IDLE_TX);
		random_burst(150);
		wait_idle();
		random_burst(150);
		wait_idle();

		// Tight band: class flips on nearly every update
		set_idle(IDLE_RX);
		write_cfg(1, 1, -3, 3, -1, 1);
		random_burst(150);
		wait_idle();

		// Widest limits and largest weights; hit weight write with the spare bit set
		set_idle(IDLE_BOTH);
		write_cfg(65535, 32767, -32768, 32767, -32768, 32767);
		random_burst(250);
		wait_idle();

		// Inconsistent settings: every item ignored
		set_idle(IDLE_NONE);
		write_cfg(0, 1, -20, 20, -5, 5);
		random_burst(15);
		wait_idle();
		write_cfg(4, 0, -20, 20, -5, 5);
		random_burst(15);
		wait_idle();
		write_cfg(4, 1, 20, 20, 20, 20);
		random_burst(15);
		wait_idle();
		write_cfg(4, 1, -20, 20, -21, 5);
		random_burst(15);
		wait_idle();
		write_cfg(4, 1, -20, 20, -5, 21);
		random_burst(15);
		wait_idle();
		write_cfg(4, 1, -20, 20, 5, 5);
		random_burst(15);
		wait_idle();

		// Random narrow settings; stored scores land outside the new limits
		for (int p = 0; p < 3; p++) begin
			set_idle(IDLE_TX + p);
			rand_cfg();
			random_burst(230);
			wait_idle();
		end

		// Limits pinned at the bottom and at the top of the score range
		set_idle(IDLE_NONE);
		write_cfg(32767, 32767, -32768, -32767, -32768, -32767);
		random_burst(120);
		wait_idle();
		set_idle(IDLE_TX);
		write_cfg(5, 32767, 32766, 32767, 32766, 32767);
		random_burst(120);
		wait_idle();

		// Back to reset settings: clamp pulls scores back into range
		set_idle(IDLE_BOTH);
		write_cfg(4, 1, -20, 20, -5, 5);
		random_burst(170);
		wait_idle();

		// Run on at the end to catch stray result transfers
		repeat (16) @(posedge clk);

		$display("checked %0d results from %0d input transfers over %0d register settings",
			n_checked, n_items, n_cfg);
		$display("idling: none, sender, receiver and both sides; %0d errors", n_errors);
		if (n_errors == 0 && due_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/ocsu_pkg.sv
hw/rtl/ocsu_ram.sv
hw/rtl/ocsu_cfg_regs.sv
hw/rtl/ocsu_cell_update.sv
hw/rtl/occupancy_score_cell_update_unit.sv
dv/tb.sv
